// ===== src/ordered_list_engine_core_assert.svh =====
// Assertion macros used by the ordered list engine datapath.
`ifndef ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define OLIST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define OLIST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define OLIST_ASSERT_IMPL(lbl, ante, cons, msg)
`define OLIST_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/olist_pkg.sv =====
// Shared constants, codes and item types for the ordered list engine.
package olist_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FUNC_W     = 3;
  localparam int POS_W      = 5;
  localparam int STAT_W     = 2;
  localparam int ECNT_W     = 5;

  // request selector
  localparam logic [FUNC_W-1:0] FN_APPEND       = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT_FRONT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INSERT_AT    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DELETE_FIRST = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DELETE_AT    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DELETE_LAST  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SEARCH       = 3'd6;

  // result status
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]            func;
    logic signed [DATA_WIDTH-1:0] value;
    logic [POS_W-1:0]             position;
    logic                         read_all;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]            status;
    logic signed [DATA_WIDTH-1:0] data_out;
    logic                         found;
    logic [ECNT_W-1:0]            entry_count;
    logic                         last;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request
    logic exec;       // apply request, emit its result
    logic read_step;  // emit one readout entry
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic read_all;
    logic empty;
    logic rd_last;
  } dp_stat_t;

endpackage

// ===== src/olist_ctrl.sv =====
// Sequencer for the ordered list engine: accept, execute, readout.
module olist_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  olist_pkg::dp_stat_t   stat_i,
  output olist_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.read_all && !stat_i.empty) begin
          state_d = S_READ;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.read_step = 1'b1;
        if (stat_i.rd_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== src/olist_datapath.sv =====
// Cell row, request decode, search compare and result register.
`include "ordered_list_engine_core_assert.svh"

module olist_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  olist_pkg::req_t       req_i,
  input  olist_pkg::ctrl_cmd_t  cmd_i,
  output olist_pkg::dp_stat_t   stat_o,
  output logic                  valid_o,
  output olist_pkg::rsp_t       rsp_o
);

  localparam int CAP   = olist_pkg::CAPACITY;
  localparam int DW    = olist_pkg::DATA_WIDTH;
  localparam int CNT_W = olist_pkg::CNT_W;
  localparam int IDX_W = olist_pkg::IDX_W;
  localparam int POS_W = olist_pkg::POS_W;
  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  olist_pkg::req_t  req_q;
  olist_pkg::rsp_t  rsp_q, rsp_d;
  logic             valid_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] rd_q;
  logic [DW-1:0]    cells_q [CAP];

  logic [DW-1:0]    prev_cell [CAP];
  logic [DW-1:0]    next_cell [CAP];
  logic [CAP-1:0]   hit;

  logic                          empty, full, do_ins, do_del, fnd, lst;
  logic [olist_pkg::STAT_W-1:0]  st;
  logic [CNT_W-1:0]              pos_k;
  logic [CMP_W-1:0]              pos_m1, cnt_x;
  logic [IDX_W-1:0]              rd_addr;
  logic [DW-1:0]                 rd_data;
  logic                          rd_last;

  assign empty  = (cnt_q == '0);
  assign full   = (cnt_q == CNT_W'(CAP));
  assign pos_m1 = CMP_W'(req_q.position) - CMP_W'(1);
  assign cnt_x  = CMP_W'(cnt_q);

  // neighbor taps for shifting inserts and deletes
  always_comb begin
    prev_cell[0]     = req_q.value;
    next_cell[CAP-1] = cells_q[CAP-1];
    for (int i = 1; i < CAP; i++) begin
      prev_cell[i] = cells_q[i-1];
    end
    for (int i = 0; i < CAP - 1; i++) begin
      next_cell[i] = cells_q[i+1];
    end
  end

  // search compares every live cell in parallel
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      hit[i] = (cells_q[i] == req_q.value) && (CNT_W'(i) < cnt_q);
    end
  end

  always_comb begin
    st     = olist_pkg::ST_OK;
    do_ins = 1'b0;
    do_del = 1'b0;
    pos_k  = '0;
    fnd    = 1'b0;
    lst    = 1'b0;
    if (req_q.read_all) begin
      st  = empty ? olist_pkg::ST_EMPTY : olist_pkg::ST_OK;
      lst = 1'b1;
    end else begin
      case (req_q.func)
        olist_pkg::FN_APPEND: begin
          if (full) st = olist_pkg::ST_FULL;
          else begin
            do_ins = 1'b1;
            pos_k  = cnt_q;
          end
        end
        olist_pkg::FN_INSERT_FRONT: begin
          if (full) st = olist_pkg::ST_FULL;
          else do_ins = 1'b1;
        end
        olist_pkg::FN_INSERT_AT: begin
          if (full) st = olist_pkg::ST_FULL;
          else if (req_q.position == '0 || pos_m1 > cnt_x) st = olist_pkg::ST_RANGE;
          else begin
            do_ins = 1'b1;
            pos_k  = CNT_W'(pos_m1);
          end
        end
        olist_pkg::FN_DELETE_FIRST: begin
          if (empty) st = olist_pkg::ST_EMPTY;
          else do_del = 1'b1;
        end
        olist_pkg::FN_DELETE_AT: begin
          if (empty) st = olist_pkg::ST_EMPTY;
          else if (req_q.position == '0 || pos_m1 >= cnt_x) st = olist_pkg::ST_RANGE;
          else begin
            do_del = 1'b1;
            pos_k  = CNT_W'(pos_m1);
          end
        end
        olist_pkg::FN_DELETE_LAST: begin
          if (empty) st = olist_pkg::ST_EMPTY;
          else begin
            do_del = 1'b1;
            pos_k  = cnt_q - CNT_W'(1);
          end
        end
        olist_pkg::FN_SEARCH: begin
          if (empty) st = olist_pkg::ST_EMPTY;
          else fnd = |hit;
        end
        default: begin
          st = olist_pkg::ST_OK;
        end
      endcase
    end
  end

  // single read port, shared by deletes and readout
  assign rd_addr = cmd_i.read_step ? rd_q : pos_k[IDX_W-1:0];
  assign rd_data = cells_q[rd_addr];
  assign rd_last = ((CNT_W'(rd_q) + CNT_W'(1)) == cnt_q);

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.exec && do_ins) cnt_d = cnt_q + CNT_W'(1);
    if (cmd_i.exec && do_del) cnt_d = cnt_q - CNT_W'(1);
  end

  always_comb begin
    rsp_d = rsp_q;
    if (cmd_i.exec) begin
      rsp_d.status      = st;
      rsp_d.data_out    = do_del ? $signed(rd_data) : '0;
      rsp_d.found       = fnd;
      rsp_d.entry_count = olist_pkg::ECNT_W'(cnt_d);
      rsp_d.last        = lst;
    end else if (cmd_i.read_step) begin
      rsp_d.status      = olist_pkg::ST_OK;
      rsp_d.data_out    = $signed(rd_data);
      rsp_d.found       = 1'b0;
      rsp_d.entry_count = olist_pkg::ECNT_W'(cnt_q);
      rsp_d.last        = rd_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      rd_q    <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      valid_q <= cmd_i.exec | cmd_i.read_step;
      if (cmd_i.load) rd_q <= '0;
      else if (cmd_i.read_step) rd_q <= rd_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    rsp_q <= rsp_d;
    for (int i = 0; i < CAP; i++) begin
      if (cmd_i.exec && do_ins) begin
        if (CNT_W'(i) == pos_k) cells_q[i] <= req_q.value;
        else if (CNT_W'(i) > pos_k) cells_q[i] <= prev_cell[i];
      end else if (cmd_i.exec && do_del) begin
        if (CNT_W'(i) >= pos_k) cells_q[i] <= next_cell[i];
      end
    end
  end

  assign stat_o.read_all = req_q.read_all;
  assign stat_o.empty    = empty;
  assign stat_o.rd_last  = rd_last;
  assign valid_o         = valid_q;
  assign rsp_o           = rsp_q;

  `OLIST_ASSERT_IMPL(a_cnt_max, 1'b1, cnt_q <= CNT_W'(CAP), "entry count above capacity")
  `OLIST_ASSERT_NEXT(a_cnt_hold, !cmd_i.exec, $stable(cnt_q), "count moved without execute")
  `OLIST_ASSERT_IMPL(a_rd_range, cmd_i.read_step, CNT_W'(rd_q) < cnt_q, "readout past tail")
  `OLIST_ASSERT_NEXT(a_emit, cmd_i.exec || cmd_i.read_step, valid_q, "result strobe missing")

endmodule

// ===== src/ordered_list_engine_core.sv =====
// Top level of the ordered list engine: sequencer plus cell-row datapath.
//
// Ordered list of up to 16 signed 32-bit entries, front first, held in a row
// of registers that shifts by one cell on insert and delete. A request is
// taken at a rising edge with start high and busy low; busy rises for the
// cycles that follow. An ordinary request is captured in the idle state,
// then decoded, the row shifted and the result registered in the execute
// state; a new request is taken only once busy is low again. A readout
// (read_all set, list not empty) emits one entry per cycle through the row's
// single read port. Each result is presented on rsp_o for exactly one cycle
// with valid_o high and cannot be held off; the last result of a request
// appears as busy drops, so a new request may be issued alongside it. Every
// result carries status (ok, empty, full, position out of range) and the
// entry count after the operation; readout marks its final entry with last.
// Entries are never cleared: only cells below the count are read.
module ordered_list_engine_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  olist_pkg::req_t  req_i,
  output logic             valid_o,
  output olist_pkg::rsp_t  rsp_o
);

  olist_pkg::ctrl_cmd_t cmd;
  olist_pkg::dp_stat_t  stat;

  // sequencer: idle -> execute -> (readout) -> idle
  olist_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // cell row, decode, search and result register
  olist_datapath u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

endmodule
